@@ rtl/sparse_context_bit_counter_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sparse context bit counter
// Implication checks that vanish when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SPARSE_CONTEXT_BIT_COUNTER_ASSERT_SVH
`define SPARSE_CONTEXT_BIT_COUNTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SCBC_ASSERT_NOW(lbl, ck, rn, cond, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond) |-> (prop)) \
        else $error("scbc assertion failed");
`define SCBC_ASSERT_NEXT(lbl, ck, rn, cond, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (prop)) \
        else $error("scbc assertion failed");
`else
`define SCBC_ASSERT_NOW(lbl, ck, rn, cond, prop)
`define SCBC_ASSERT_NEXT(lbl, ck, rn, cond, prop)
`endif
`endif

@@ rtl/scbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Sparse context bit counter package
// Word types and fixed constants of the block.
// ----------------------------------------------------------------------------
`default_nettype none
package scbc_pkg;
    localparam int HIST_W    = 64;
    localparam int PART_W    = 7;
    localparam int BIB_W     = 3;
    localparam int KEY_P_W   = 10;
    localparam int POS_W     = 20;
    localparam int OUT_CNT_W = 16;
    localparam int EPOCH_W   = 4;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam logic [0:0] REG_CONTEXT_MASK = 1'b0;

    typedef struct packed {
        logic data_bit;
        logic block_start;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]     bit_position;
        logic                 boost;
        logic [OUT_CNT_W-1:0] count_same;
        logic [OUT_CNT_W-1:0] count_other;
        logic                 table_full;
    } result_t;
endpackage
`default_nettype wire

@@ rtl/sparse_context_bit_counter.sv @@
// ----------------------------------------------------------------------------
// Sparse context bit counter
// Per-bit context lookup in a linear-probed table with two counts per slot.
// ----------------------------------------------------------------------------
// A bit takes a read state and a check state for each probe of the
// single-port table memory. A lookup that has a result ready waits while
// the previous result word is still unaccepted. A block start that wraps
// the slot epoch, and every reset, runs a clearing pass over all
// TABLE_DEPTH slots before lookups resume.
`default_nettype none
module sparse_context_bit_counter #(
    parameter int TABLE_DEPTH    = 4096,
    parameter int COUNT_WIDTH    = 16,
    parameter int MAX_BLOCK_BITS = 2048
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              src_valid,
    output logic                                   src_ready,
    input  wire scbc_pkg::item_t                   src_word,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output scbc_pkg::result_t                      res_word,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [scbc_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [scbc_pkg::PDATA_W-1:0]      pwdata,
    output logic [scbc_pkg::PDATA_W-1:0]           prdata,
    output logic                                   pready
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = scbc_pkg::EPOCH_W + scbc_pkg::HIST_W + scbc_pkg::KEY_P_W
                        + 2 * COUNT_WIDTH;
    localparam int KW = scbc_pkg::HIST_W + scbc_pkg::KEY_P_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);
    localparam logic [AW:0] DEPTH_EXT = (AW + 1)'(TABLE_DEPTH);
    localparam logic [scbc_pkg::POS_W-1:0] POS_LIMIT = scbc_pkg::POS_W'(MAX_BLOCK_BITS);
    localparam logic [scbc_pkg::EPOCH_W-1:0] EPOCH_FIRST = scbc_pkg::EPOCH_W'(1);

    typedef enum logic [1:0] {S_IDLE, S_CLEAR, S_READ, S_CHECK} state_t;

    state_t                           state_reg, state_next;
    logic [scbc_pkg::EPOCH_W-1:0]     epoch_reg, epoch_next;
    logic [AW-1:0]                    clr_reg, clr_next;
    logic                             pend_reg, pend_next;
    logic [AW-1:0]                    probe_reg, probe_next;
    logic [AW-1:0]                    pcnt_reg, pcnt_next;
    logic [scbc_pkg::HIST_W-1:0]      hist_reg, hist_next;
    logic [scbc_pkg::PART_W-1:0]      part_reg, part_next;
    logic [scbc_pkg::BIB_W-1:0]       bib_reg, bib_next;
    logic [scbc_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [scbc_pkg::HIST_W-1:0]      khist_reg, khist_next;
    logic [scbc_pkg::KEY_P_W-1:0]     kpart_reg, kpart_next;
    logic                             bit_reg, bit_next;
    logic [scbc_pkg::POS_W-1:0]       kpos_reg, kpos_next;
    logic                             oval_reg, oval_next;
    scbc_pkg::result_t                out_reg, out_next;
    logic [7:0]                       mask_reg;

    logic [EW-1:0] mem [TABLE_DEPTH];
    logic [EW-1:0] rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;

    logic                           acc, blk, out_free;
    logic [scbc_pkg::HIST_W-1:0]    sel, e_hist;
    logic [scbc_pkg::PART_W-1:0]    e_part;
    logic [scbc_pkg::BIB_W-1:0]     e_bib;
    logic [scbc_pkg::POS_W-1:0]     e_pos;
    logic [scbc_pkg::KEY_P_W-1:0]   e_key_p;
    logic [KW-1:0]                  hkey;
    logic [AW-1:0]                  hfold;
    logic [AW:0]                    hsub;
    logic [scbc_pkg::EPOCH_W-1:0]   rd_tag;
    logic [scbc_pkg::HIST_W-1:0]    rd_hist;
    logic [scbc_pkg::KEY_P_W-1:0]   rd_part;
    logic [COUNT_WIDTH-1:0]         rd_c1, rd_c0, cs, co, cs_upd, co_upd, n1, n0;
    logic                           live, match;
    logic [31:0]                    cs32, co32;
    logic [7:0]                     byte_done;

    assign pready    = 1'b1;
    assign src_ready = (state_reg == S_IDLE);
    assign res_valid = oval_reg;
    assign res_word  = out_reg;
    assign prdata    = (paddr[2] == scbc_pkg::REG_CONTEXT_MASK) ?
                       scbc_pkg::PDATA_W'(mask_reg) : '0;

    assign acc      = src_valid && src_ready;
    assign blk      = src_word.block_start;
    assign out_free = !oval_reg || res_ready;
    assign e_hist   = blk ? '0 : hist_reg;
    assign e_part   = blk ? '0 : part_reg;
    assign e_bib    = blk ? '0 : bib_reg;
    assign e_pos    = blk ? '0 : pos_reg;
    assign e_key_p  = {e_bib, e_part};
    assign hkey     = {e_key_p, e_hist & sel};
    assign byte_done = {e_part, src_word.data_bit};

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            sel[8*i +: 8] = {8{mask_reg[i]}};
        end
    end

    always_comb
    begin
        hfold = '0;
        for (int i = 0; i < KW; i++)
        begin
            hfold[i % AW] = hfold[i % AW] ^ hkey[i];
        end
        hsub = {1'b0, hfold} - DEPTH_EXT;
    end

    assign {rd_tag, rd_hist, rd_part, rd_c1, rd_c0} = rdata_reg;
    assign live   = (rd_tag == epoch_reg);
    assign match  = (rd_part == kpart_reg) && ((rd_hist & sel) == (khist_reg & sel));
    assign cs     = bit_reg ? rd_c1 : rd_c0;
    assign co     = bit_reg ? rd_c0 : rd_c1;
    assign cs_upd = (cs != '1) ? cs + 1'b1 : cs;
    assign co_upd = (co > COUNT_WIDTH'(1)) ? (co >> 1) : co;
    assign n1     = bit_reg ? cs_upd : co_upd;
    assign n0     = bit_reg ? co_upd : cs_upd;
    assign cs32   = 32'(cs);
    assign co32   = 32'(co);

    always_comb
    begin
        state_next = state_reg;
        epoch_next = epoch_reg;
        clr_next   = clr_reg;
        pend_next  = pend_reg;
        probe_next = probe_reg;
        pcnt_next  = pcnt_reg;
        hist_next  = hist_reg;
        part_next  = part_reg;
        bib_next   = bib_reg;
        pos_next   = pos_reg;
        khist_next = khist_reg;
        kpart_next = kpart_reg;
        bit_next   = bit_reg;
        kpos_next  = kpos_reg;
        oval_next  = oval_reg && !res_ready;
        out_next   = out_reg;
        mem_we     = 1'b0;
        mem_waddr  = clr_reg;
        mem_wdata  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (blk)
                    begin
                        hist_next = '0;
                        part_next = '0;
                        bib_next  = '0;
                        pos_next  = '0;
                    end
                    if (e_pos < POS_LIMIT)
                    begin
                        khist_next = e_hist;
                        kpart_next = e_key_p;
                        bit_next   = src_word.data_bit;
                        kpos_next  = e_pos;
                        probe_next = hsub[AW] ? hfold : hsub[AW-1:0];
                        pcnt_next  = '0;
                        pos_next   = e_pos + 1'b1;
                        if (e_bib == '1)
                        begin
                            hist_next = {byte_done, e_hist[scbc_pkg::HIST_W-1:8]};
                            part_next = '0;
                            bib_next  = '0;
                        end
                        else
                        begin
                            hist_next = e_hist;
                            part_next = byte_done[scbc_pkg::PART_W-1:0];
                            bib_next  = e_bib + 1'b1;
                        end
                        state_next = S_READ;
                        if (blk)
                        begin
                            if (epoch_reg == '1)
                            begin
                                epoch_next = EPOCH_FIRST;
                                clr_next   = '0;
                                pend_next  = 1'b1;
                                state_next = S_CLEAR;
                            end
                            else
                            begin
                                epoch_next = epoch_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_SLOT)
                begin
                    pend_next  = 1'b0;
                    state_next = pend_reg ? S_READ : S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                mem_waddr = probe_reg;
                if (!live)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = {epoch_reg, khist_reg, kpart_reg,
                                  COUNT_WIDTH'(bit_reg), COUNT_WIDTH'(!bit_reg)};
                    state_next = S_IDLE;
                end
                else if (match)
                begin
                    if (((cs | co) == '0) || out_free)
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = {epoch_reg, rd_hist, rd_part, n1, n0};
                        state_next = S_IDLE;
                        if ((cs | co) != '0)
                        begin
                            oval_next            = 1'b1;
                            out_next.bit_position = kpos_reg;
                            out_next.boost       = (cs == '0) || (co == '0);
                            out_next.count_same  = cs32[scbc_pkg::OUT_CNT_W-1:0];
                            out_next.count_other = co32[scbc_pkg::OUT_CNT_W-1:0];
                            out_next.table_full  = 1'b0;
                        end
                    end
                end
                else if (pcnt_reg == LAST_SLOT)
                begin
                    if (out_free)
                    begin
                        oval_next             = 1'b1;
                        out_next.bit_position = kpos_reg;
                        out_next.boost        = 1'b0;
                        out_next.count_same   = '0;
                        out_next.count_other  = '0;
                        out_next.table_full   = 1'b1;
                        state_next            = S_IDLE;
                    end
                end
                else
                begin
                    probe_next = (probe_reg == LAST_SLOT) ? '0 : probe_reg + 1'b1;
                    pcnt_next  = pcnt_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            epoch_reg <= EPOCH_FIRST;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            probe_reg <= '0;
            pcnt_reg  <= '0;
            hist_reg  <= '0;
            part_reg  <= '0;
            bib_reg   <= '0;
            pos_reg   <= '0;
            khist_reg <= '0;
            kpart_reg <= '0;
            bit_reg   <= 1'b0;
            kpos_reg  <= '0;
            oval_reg  <= 1'b0;
            out_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            epoch_reg <= epoch_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            probe_reg <= probe_next;
            pcnt_reg  <= pcnt_next;
            hist_reg  <= hist_next;
            part_reg  <= part_next;
            bib_reg   <= bib_next;
            pos_reg   <= pos_next;
            khist_reg <= khist_next;
            kpart_reg <= kpart_next;
            bit_reg   <= bit_next;
            kpos_reg  <= kpos_next;
            oval_reg  <= oval_next;
            out_reg   <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (psel && penable && pwrite && pready &&
                 (paddr[2] == scbc_pkg::REG_CONTEXT_MASK))
        begin
            mask_reg <= pwdata[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == S_READ)
        begin
            rdata_reg <= mem[probe_reg];
        end
    end

`include "sparse_context_bit_counter_assert.svh"

    `SCBC_ASSERT_NOW(a_we_busy, clk, rst_n, mem_we, state_reg != S_IDLE)
    `SCBC_ASSERT_NEXT(a_read_check, clk, rst_n, state_reg == S_READ, state_reg == S_CHECK)
    `SCBC_ASSERT_NOW(a_epoch_nz, clk, rst_n, state_reg == S_CHECK, epoch_reg != '0)
    `SCBC_ASSERT_NEXT(a_out_hold, clk, rst_n, res_valid && !res_ready, res_valid)

endmodule
`default_nettype wire
